// ----- hdl/oaht_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and modular helpers for the open addressing hash table
package oaht_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_BYTES   = 8;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int N_W         = IDX_W + 1;
   localparam int LEN_W       = 4;
   localparam int KEY_W       = 64;
   localparam int VAL_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int MOD_STEPS   = KEY_W / 4;
   localparam int SETUP_STEPS = 11;
   localparam int C7_STEPS    = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE  = 2'd2;

   localparam logic [KEY_W-1:0] MX_INIT  = 64'd3323198485;
   localparam logic [VAL_W-1:0] MX_MUL   = 32'h5bd1e995;
   localparam logic [KEY_W-1:0] PJW_MASK = 64'h00000000f0000000;
   localparam logic [KEY_W-1:0] DJB_INIT = 64'd5381;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_NO_SLOT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FLAG_EMPTY = 2'd0,
      FLAG_USED  = 2'd1,
      FLAG_TOMB  = 2'd2
   } flag_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_HASH_A, S_HASH_B, S_MOD_LOAD, S_MOD,
      S_SETUP, S_SETUP_FIN, S_READ, S_EVAL, S_FINISH
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       hash_a;
      logic       hash_b;
      logic       mod_start;
      logic       mod_step;
      logic       setup_step;
      logic       c7_en;
      logic       setup_fin;
      logic       mem_rd;
      logic       probe_adv;
      logic       wr_slot;
      logic       wr_tomb;
      logic       fin;
      status_type fin_status;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type          op;
      logic [LEN_W-1:0] key_len;
      logic             cnt_ge_n;
      logic             cnt_zero;
      flag_type         flag;
      logic             key_match;
      logic             at_h1;
      logic             i_zero;
      logic             i_last;
      logic             out_free;
   } dp_stat_type;

   // (a + b) mod n, both operands already below n
   function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b,
                                                input logic [N_W-1:0] n);
      logic [N_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= n) s = s - n;
      return s[IDX_W-1:0];
   endfunction

   // one restoring step of a bit serial remainder
   function automatic logic [IDX_W-1:0] mod_shift(input logic [IDX_W-1:0] r,
                                                  input logic b,
                                                  input logic [N_W-1:0] n);
      logic [N_W-1:0] s;
      s = {r, b};
      if (s >= n) s = s - n;
      return s[IDX_W-1:0];
   endfunction

endpackage

// ----- hdl/oaht_if.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces
interface oaht_req_if import oaht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       command;
   logic [KEY_W-1:0] key_bytes;
   logic [LEN_W-1:0] key_length;
   logic [VAL_W-1:0] data_value;
   modport source (output valid, command, key_bytes, key_length, data_value, input ready);
   modport sink (input valid, command, key_bytes, key_length, data_value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [VAL_W-1:0] found_value;
   logic [N_W-1:0]   probe_steps;
   logic [N_W-1:0]   entry_count;
   modport source (output valid, status, found_value, probe_steps, entry_count, input ready);
   modport sink (input valid, status, found_value, probe_steps, entry_count, output ready);
endinterface

// ----- hdl/oaht_dp.sv -----
`timescale 1ns / 1ps
// datapath: hashing, serial modulo, probe index, slot memories and result register
module oaht_dp import oaht_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0]            req_command,
   input  logic [KEY_W-1:0]      req_key_bytes,
   input  logic [LEN_W-1:0]      req_key_length,
   input  logic [VAL_W-1:0]      req_data_value,
   input  dp_cmd_type            ctl,
   output dp_stat_type           stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [VAL_W-1:0]      rsp_found_value,
   output logic [N_W-1:0]        rsp_probe_steps,
   output logic [N_W-1:0]        rsp_entry_count
);

   logic                  hash_sel_ff;
   logic                  probe_mode_ff;
   logic [CSR_DATA_W-1:0] table_size_ff;
   logic [N_W-1:0]        n;

   cmd_type          op_ff;
   logic [KEY_W-1:0] key_ff, key_sh_ff;
   logic [LEN_W-1:0] len_ff;
   logic [VAL_W-1:0] val_ff;
   logic [LEN_W-1:0] len_sat;
   logic [KEY_W-1:0] key_masked;

   logic [KEY_W-1:0] mx_ff, pjw_ff, djb_ff;
   logic [KEY_W-1:0] prod_lo_ff;
   logic [VAL_W-1:0] mx_hi_ff;
   logic [KEY_W-1:0] mx_x, mx_p, pjw_t, pjw_g, djb_t;
   logic [VAL_W-1:0] hi_prod;
   logic [7:0]       cur_byte;

   logic [KEY_W-1:0] mod_a_ff, mod_b_ff;
   logic [IDX_W-1:0] r1_ff, r2_ff, r1_in, r2_in;

   logic [IDX_W-1:0] m11_ff, c7_ff, c14_ff, d_ff, idx_ff;
   logic [N_W-1:0]   i_ff;
   logic [N_W-1:0]   used_cnt_ff;

   entry_type               slot_mem [TABLE_DEPTH];
   flag_type                flag_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff;
   entry_type               ent_q;
   flag_type                flag_q;
   logic                    vld_q;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [VAL_W-1:0]        rsp_found_ff;
   logic [N_W-1:0]          rsp_steps_ff;
   logic [N_W-1:0]          rsp_count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_sel_ff   <= 1'b0;
         probe_mode_ff <= 1'b0;
         table_size_ff <= CSR_DATA_W'(TABLE_DEPTH);
      end else if (csr_we) begin
         case (csr_index)
            CSR_HASH_SELECT: hash_sel_ff   <= csr_wdata[0];
            CSR_PROBE_MODE:  probe_mode_ff <= csr_wdata[0];
            CSR_TABLE_SIZE:  table_size_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      if (table_size_ff == '0) n = N_W'(1);
      else if (table_size_ff > CSR_DATA_W'(TABLE_DEPTH)) n = N_W'(TABLE_DEPTH);
      else n = N_W'(table_size_ff);
   end

   always_comb begin
      len_sat = (req_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req_key_length;
      for (int k = 0; k < KEY_BYTES; k++)
         key_masked[8*k +: 8] = (LEN_W'(k) < len_sat) ? req_key_bytes[8*k +: 8] : 8'h00;
   end

   // hash arithmetic, one key byte per S_HASH_A and S_HASH_B pair
   always_comb begin
      cur_byte = key_sh_ff[7:0];
      mx_x     = mx_ff ^ {56'd0, cur_byte};
      hi_prod  = mx_hi_ff * MX_MUL;
      mx_p     = prod_lo_ff + {hi_prod, 32'd0};
      pjw_t    = (pjw_ff << 4) + {56'd0, cur_byte};
      pjw_g    = pjw_t & PJW_MASK;
      if (pjw_g != '0) pjw_t = pjw_t ^ (pjw_g >> 24) ^ pjw_g;
      djb_t    = (djb_ff << 5) + djb_ff + {56'd0, cur_byte};
   end

   always_comb begin
      r1_in = r1_ff;
      r2_in = r2_ff;
      for (int j = 0; j < 4; j++) begin
         r1_in = mod_shift(r1_in, mod_a_ff[KEY_W-1-j], n);
         r2_in = mod_shift(r2_in, mod_b_ff[KEY_W-1-j], n);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff     <= cmd_type'(req_command);
         key_ff    <= key_masked;
         key_sh_ff <= key_masked;
         len_ff    <= len_sat;
         val_ff    <= req_data_value;
         mx_ff     <= MX_INIT;
         pjw_ff    <= '0;
         djb_ff    <= DJB_INIT;
         i_ff      <= '0;
      end
      if (ctl.hash_a) begin
         prod_lo_ff <= 64'(mx_x[31:0]) * 64'(MX_MUL);
         mx_hi_ff   <= mx_x[63:32];
      end
      if (ctl.hash_b) begin
         mx_ff     <= mx_p ^ (mx_p >> 15);
         pjw_ff    <= pjw_t;
         djb_ff    <= djb_t;
         key_sh_ff <= key_sh_ff >> 8;
      end
      if (ctl.mod_start) begin
         mod_a_ff <= hash_sel_ff ? pjw_ff : mx_ff;
         mod_b_ff <= djb_ff;
         r1_ff    <= '0;
         r2_ff    <= '0;
         m11_ff   <= '0;
         c7_ff    <= '0;
      end
      if (ctl.mod_step) begin
         r1_ff    <= r1_in;
         r2_ff    <= r2_in;
         mod_a_ff <= mod_a_ff << 4;
         mod_b_ff <= mod_b_ff << 4;
      end
      if (ctl.setup_step) begin
         m11_ff <= mod_add(m11_ff, r2_ff, n);
         if (ctl.c7_en) c7_ff <= mod_add(c7_ff, IDX_W'(1), n);
      end
      if (ctl.setup_fin) begin
         c14_ff <= mod_add(c7_ff, c7_ff, n);
         d_ff   <= probe_mode_ff ? mod_add(m11_ff, c7_ff, n) : r2_ff;
         idx_ff <= r1_ff;
         i_ff   <= '0;
      end
      if (ctl.probe_adv) begin
         idx_ff <= mod_add(idx_ff, d_ff, n);
         if (probe_mode_ff) d_ff <= mod_add(d_ff, c14_ff, n);
         i_ff   <= i_ff + N_W'(1);
      end
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (ctl.mem_rd) begin
         ent_q  <= slot_mem[idx_ff];
         flag_q <= flag_mem[idx_ff];
      end
      if (ctl.wr_slot) begin
         slot_mem[idx_ff] <= '{key: key_ff, len: len_ff, value: val_ff};
         flag_mem[idx_ff] <= FLAG_USED;
      end else if (ctl.wr_tomb) begin
         flag_mem[idx_ff] <= FLAG_TOMB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         vld_q       <= 1'b0;
         used_cnt_ff <= '0;
      end else begin
         if (ctl.mem_rd) vld_q <= valid_ff[idx_ff];
         if (ctl.wr_slot || ctl.wr_tomb) valid_ff[idx_ff] <= 1'b1;
         if (ctl.wr_slot) used_cnt_ff <= used_cnt_ff + N_W'(1);
         else if (ctl.wr_tomb) used_cnt_ff <= used_cnt_ff - N_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fin) begin
         rsp_status_ff <= ctl.fin_status;
         rsp_found_ff  <= (ctl.fin_status == ST_OK && op_ff == CMD_SEARCH) ? ent_q.value : '0;
         rsp_steps_ff  <= i_ff;
         rsp_count_ff  <= used_cnt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_probe_steps = rsp_steps_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_comb begin
      stat.op        = op_ff;
      stat.key_len   = len_ff;
      stat.cnt_ge_n  = (used_cnt_ff >= n);
      stat.cnt_zero  = (used_cnt_ff == '0);
      stat.flag      = vld_q ? flag_q : FLAG_EMPTY;
      stat.key_match = (ent_q.key == key_ff) && (ent_q.len == len_ff);
      stat.at_h1     = (idx_ff == r1_ff);
      stat.i_zero    = (i_ff == '0);
      stat.i_last    = ({1'b0, i_ff} + (N_W+1)'(1)) > {1'b0, n};
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

`ifndef SYNTH
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_slot |=> used_cnt_ff == $past(used_cnt_ff) + N_W'(1))
      else $error("entry count did not follow insert");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.mem_rd |-> {1'b0, idx_ff} < n)
      else $error("probe index outside table");
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      ctl.fin |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_slot && ctl.wr_tomb))
      else $error("insert and delete write together");
`endif

endmodule

// ----- hdl/oaht_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine sequencing hash, modulo, setup and probe phases
module oaht_ctrl import oaht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  ctl
);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [3:0]       step_cnt_ff, step_cnt_in;
   status_type       status_ff, status_in;

   logic is_insert, ev_free, ev_wrap, ev_hit, ev_empty;

   always_comb begin
      is_insert = (stat.op == CMD_INSERT);
      ev_free   = (stat.flag != FLAG_USED);
      ev_wrap   = !stat.i_zero && stat.at_h1;
      ev_hit    = (stat.flag == FLAG_USED) && stat.key_match;
      ev_empty  = (stat.flag == FLAG_EMPTY);
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      byte_cnt_in = byte_cnt_ff;
      step_cnt_in = step_cnt_ff;
      status_in   = status_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            byte_cnt_in = '0;
            if (is_insert && stat.cnt_ge_n) begin
               status_in = ST_FULL;
               state_in  = S_FINISH;
            end else if ((stat.op == CMD_DELETE && stat.cnt_zero) || stat.op == CMD_NOP) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else if (stat.key_len == '0) begin
               state_in = S_MOD_LOAD;
            end else begin
               state_in = S_HASH_A;
            end
         end
         S_HASH_A: state_in = S_HASH_B;
         S_HASH_B: begin
            byte_cnt_in = byte_cnt_ff + LEN_W'(1);
            state_in    = (byte_cnt_in == stat.key_len) ? S_MOD_LOAD : S_HASH_A;
         end
         S_MOD_LOAD: begin
            step_cnt_in = '0;
            state_in    = S_MOD;
         end
         S_MOD: begin
            step_cnt_in = step_cnt_ff + 4'd1;
            if (step_cnt_ff == 4'(MOD_STEPS - 1)) begin
               step_cnt_in = '0;
               state_in    = S_SETUP;
            end
         end
         S_SETUP: begin
            step_cnt_in = step_cnt_ff + 4'd1;
            if (step_cnt_ff == 4'(SETUP_STEPS - 1)) state_in = S_SETUP_FIN;
         end
         S_SETUP_FIN: state_in = S_READ;
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_FINISH;
            if (is_insert) begin
               if (ev_free) status_in = ST_OK;
               else if (ev_wrap || stat.i_last) status_in = ST_NO_SLOT;
               else state_in = S_READ;
            end else begin
               if (ev_empty || ev_wrap) status_in = ST_NOT_FOUND;
               else if (ev_hit) status_in = ST_OK;
               else if (stat.i_last) status_in = ST_NOT_FOUND;
               else state_in = S_READ;
            end
         end
         S_FINISH: if (stat.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl            = '0;
      ctl.fin_status = status_ff;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         S_HASH_A:    ctl.hash_a = 1'b1;
         S_HASH_B:    ctl.hash_b = 1'b1;
         S_MOD_LOAD:  ctl.mod_start = 1'b1;
         S_MOD:       ctl.mod_step = 1'b1;
         S_SETUP: begin
            ctl.setup_step = 1'b1;
            ctl.c7_en      = (step_cnt_ff < 4'(C7_STEPS));
         end
         S_SETUP_FIN: ctl.setup_fin = 1'b1;
         S_READ:      ctl.mem_rd = 1'b1;
         S_EVAL: begin
            if (is_insert) begin
               if (ev_free) ctl.wr_slot = 1'b1;
               else if (!ev_wrap) ctl.probe_adv = 1'b1;
            end else begin
               if (!ev_empty && !ev_wrap) begin
                  if (ev_hit) ctl.wr_tomb = (stat.op == CMD_DELETE);
                  else ctl.probe_adv = 1'b1;
               end
            end
         end
         S_FINISH: ctl.fin = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         byte_cnt_ff <= '0;
         step_cnt_ff <= '0;
         status_ff   <= ST_OK;
      end else begin
         state_ff    <= state_in;
         byte_cnt_ff <= byte_cnt_in;
         step_cnt_ff <= step_cnt_in;
         status_ff   <= status_in;
      end
   end

`ifndef SYNTH
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> state_ff == S_CHECK)
      else $error("accepted beat did not start an operation");
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL |-> $past(state_ff) == S_READ)
      else $error("slot evaluated without a read");
   a_write_in_eval: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_slot || ctl.wr_tomb) |-> state_ff == S_EVAL)
      else $error("slot write outside evaluation");
`endif

endmodule

// ----- hdl/open_addressing_hash_table_unit.sv -----
`timescale 1ns / 1ps
// top level of the open addressing hash table unit
//
//   channel   dir   handshake          payload
//   req_port  in    valid/ready beat   command, key_bytes, key_length, data_value
//   rsp_port  out   valid/ready beat   status, found_value, probe_steps, entry_count
//   csr_*     in    csr_we write       csr_index, csr_wdata
//
// one command at a time; per command: the multiply split over S_HASH_A and S_HASH_B
// for each key byte, the serial modulo unit, the probe step setup and one memory read
// plus evaluation per probe
// commands rejected up front (full table, empty delete, unused code) skip to S_FINISH
// synchronous active-high reset clears slot valid bits at once, no clearing pass
// a pending response holds its register; the next request is taken meanwhile
module open_addressing_hash_table_unit import oaht_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   oaht_req_if.sink              req_port,
   oaht_rsp_if.source            rsp_port,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  ctl;   // controller commands to datapath
   dp_stat_type stat;  // datapath status back to controller
   logic        req_ready;

   // controller owns the request handshake
   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   assign req_port.ready = req_ready;

   // datapath owns the response register
   oaht_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_command     (req_port.command),
      .req_key_bytes   (req_port.key_bytes),
      .req_key_length  (req_port.key_length),
      .req_data_value  (req_port.data_value),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_valid       (rsp_port.valid),
      .rsp_ready       (rsp_port.ready),
      .rsp_status      (rsp_port.status),
      .rsp_found_value (rsp_port.found_value),
      .rsp_probe_steps (rsp_port.probe_steps),
      .rsp_entry_count (rsp_port.entry_count)
   );

endmodule

// ----- sim/oaht_checker.sv -----
`timescale 1ns / 1ps
// checker for the hash table unit: tracks config, predicts every response, compares
module oaht_checker import oaht_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   oaht_req_if                   req,
   oaht_rsp_if                   rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending,
   output int                    table_count,
   output int                    hit_count,
   output int                    miss_count,
   output int                    full_count,
   output int                    noslot_count
);

   typedef struct {
      status_type  status;
      logic [31:0] found;
      logic [8:0]  steps;
      logic [8:0]  count;
   } outcome_type;

   outcome_type response_q[$];

   flag_type    slot_state[TABLE_DEPTH];
   logic [63:0] slot_keys[TABLE_DEPTH];
   logic [3:0]  slot_lens[TABLE_DEPTH];
   logic [31:0] slot_vals[TABLE_DEPTH];
   int unsigned live_entries;
   logic        use_pjw;
   logic        custom_probe;
   logic [8:0]  size_reg;

   function automatic longint unsigned mulxor_hash(input longint unsigned key,
                                                   input int unsigned len);
      longint unsigned h;
      h = 64'd3323198485;
      for (int k = 0; k < len; k++) begin
         h = h ^ ((key >> (8 * k)) & 64'hff);
         h = h * 64'h5bd1e995;
         h = h ^ (h >> 15);
      end
      return h;
   endfunction

   function automatic longint unsigned pjw_hash(input longint unsigned key,
                                                input int unsigned len);
      longint unsigned h, g;
      h = 0;
      for (int k = 0; k < len; k++) begin
         h = (h << 4) + ((key >> (8 * k)) & 64'hff);
         g = h & 64'hf0000000;
         if (g != 0) begin
            h = h ^ (g >> 24);
            h = h ^ g;
         end
      end
      return h;
   endfunction

   function automatic longint unsigned djb2_hash(input longint unsigned key,
                                                 input int unsigned len);
      longint unsigned h;
      h = 5381;
      for (int k = 0; k < len; k++)
         h = (h << 5) + h + ((key >> (8 * k)) & 64'hff);
      return h;
   endfunction

   function automatic int slot_at(input longint unsigned h1, input longint unsigned h2,
                                  input longint unsigned i, input longint unsigned n,
                                  input logic custom);
      longint unsigned x;
      if (custom) x = h1 + 11 * i * h2 + 7 * i * i;
      else        x = h1 + i * h2;
      return int'(x % n);
   endfunction

   task automatic predict_command(input logic [1:0] cmd, input logic [63:0] kb,
                                  input logic [3:0] kl, input logic [31:0] dv,
                                  output outcome_type r);
      int unsigned len;
      longint unsigned n, key, h1, h2, i;
      int idx;
      status_type st;
      logic [31:0] found;
      len = (kl > 8) ? 8 : kl;
      n = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg);
      key = (len >= 8) ? kb : (kb & ((64'd1 << (8 * len)) - 1));
      i = 0;
      st = ST_NOT_FOUND;
      found = '0;
      h1 = (use_pjw ? pjw_hash(key, len) : mulxor_hash(key, len)) % n;
      h2 = djb2_hash(key, len) % n;
      if (cmd == CMD_SEARCH || (cmd == CMD_DELETE && live_entries != 0)) begin
         forever begin
            idx = slot_at(h1, h2, i, n, custom_probe);
            if (slot_state[idx] == FLAG_EMPTY) break;
            if (i != 0 && idx == h1) break;
            if (slot_state[idx] == FLAG_USED && slot_lens[idx] == len &&
                slot_keys[idx] == key) begin
               st = ST_OK;
               if (cmd == CMD_SEARCH) found = slot_vals[idx];
               else begin
                  slot_state[idx] = FLAG_TOMB;
                  live_entries--;
               end
               break;
            end
            i++;
            if (i > n) break;
         end
      end else if (cmd == CMD_INSERT) begin
         if (live_entries >= n) st = ST_FULL;
         else begin
            st = ST_NO_SLOT;
            forever begin
               idx = slot_at(h1, h2, i, n, custom_probe);
               if (slot_state[idx] != FLAG_USED) begin
                  slot_state[idx] = FLAG_USED;
                  slot_keys[idx] = key;
                  slot_lens[idx] = len[3:0];
                  slot_vals[idx] = dv;
                  live_entries++;
                  st = ST_OK;
                  break;
               end
               if (i != 0 && idx == h1) break;
               i++;
               if (i > n) break;
            end
         end
      end
      r.status = st;
      r.found  = found;
      r.steps  = i[8:0];
      r.count  = live_entries[8:0];
   endtask

   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         foreach (slot_state[s]) slot_state[s] = FLAG_EMPTY;
         live_entries = 0;
         use_pjw = 1'b0;
         custom_probe = 1'b0;
         size_reg = 9'd256;
         response_q.delete();
         error_count = 0;
         hit_count = 0;
         miss_count = 0;
         full_count = 0;
         noslot_count = 0;
      end else begin
         // responses first: a beat retiring now belongs to an older request
         if (rsp.valid && rsp.ready) begin
            got.status = status_type'(rsp.status);
            got.found  = rsp.found_value;
            got.steps  = rsp.probe_steps;
            got.count  = rsp.entry_count;
            if (response_q.size() == 0) begin
               $display("%0t: response beat with nothing outstanding", $time);
               error_count++;
            end else begin
               want = response_q.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           got.status);
                  error_count++;
               end
               if (got.found !== want.found) begin
                  $display("%0t: found_value expected %h actual %h", $time, want.found,
                           got.found);
                  error_count++;
               end
               if (got.steps !== want.steps) begin
                  $display("%0t: probe_steps expected %0d actual %0d", $time, want.steps,
                           got.steps);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                           got.count);
                  error_count++;
               end
               case (want.status)
                  ST_OK:        hit_count++;
                  ST_NOT_FOUND: miss_count++;
                  ST_FULL:      full_count++;
                  default:      noslot_count++;
               endcase
            end
         end
         if (req.valid && req.ready) begin
            predict_command(req.command, req.key_bytes, req.key_length, req.data_value,
                            want);
            response_q = {response_q, want};
         end
         if (csr_we) begin
            case (csr_index)
               CSR_HASH_SELECT: use_pjw = csr_wdata[0];
               CSR_PROBE_MODE:  custom_probe = csr_wdata[0];
               CSR_TABLE_SIZE:  size_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = response_q.size();
      table_count = live_entries;
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// testbench top for the open addressing hash table unit
module tb;
   import oaht_pkg::*;

   localparam int POOL = 24;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic hold_off;

   int error_count, pending, table_count;
   int hit_count, miss_count, full_count, noslot_count;
   int burst_left;
   int sent;

   // keys reused across commands so searches and deletes actually hit
   logic [63:0] pool_key[POOL];
   logic [3:0]  pool_len[POOL];

   oaht_req_if req ();
   oaht_rsp_if rsp ();

   open_addressing_hash_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req),
      .rsp_port  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   oaht_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .pending      (pending),
      .table_count  (table_count),
      .hit_count    (hit_count),
      .miss_count   (miss_count),
      .full_count   (full_count),
      .noslot_count (noslot_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // one request beat; bursts of random length with random gaps in between
   task automatic send_beat(input cmd_type cmd, input logic [63:0] key,
                            input logic [3:0] len, input logic [31:0] value);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req.valid      = 1'b1;
      req.command    = cmd;
      req.key_bytes  = key;
      req.key_length = len;
      req.data_value = value;
      do @(posedge clock); while (!req.ready);
      burst_left--;
      sent++;
   endtask

   // pool key with fresh garbage above its length, which the block must ignore
   function automatic logic [63:0] pool_bytes(input int p);
      logic [63:0] junk;
      int unsigned len;
      junk = {$urandom, $urandom};
      len = (pool_len[p] > 8) ? 8 : pool_len[p];
      if (len >= 8) return pool_key[p];
      return pool_key[p] | (junk & ~((64'd1 << (8 * len)) - 1));
   endfunction

   // stop offering, wait for every response, then let the engine settle
   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // delete pool keys under the current config until the table is empty or six rounds have passed
   task automatic empty_table();
      for (int round = 0; round < 6 && table_count != 0; round++) begin
         for (int p = 0; p < POOL; p++)
            send_beat(CMD_DELETE, pool_bytes(p), pool_len[p], $urandom);
         drain();
      end
   endtask

   // receiver: alternating windows of random stalls and always-ready,
   // plus one long hold-off on request
   initial begin
      int window;
      logic held;
      rsp.ready = 1'b0;
      window = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp.ready = 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            window++;
            if ((window / 150) % 2 == 0) rsp.ready = ($urandom_range(0, 2) != 0);
            else rsp.ready = 1'b1;
         end
      end
   end

   initial begin
      logic [63:0] ones;
      logic [8:0] sizes[12];
      int p, roll;
      cmd_type cmd;
      ones = '1;
      sizes = '{9'd256, 9'd256, 9'd8, 9'd5, 9'd1, 9'd0, 9'd300, 9'd511, 9'd16, 9'd3,
                9'd64, 9'd2};
      req.valid = 1'b0;
      req.command = CMD_INSERT;
      req.key_bytes = '0;
      req.key_length = '0;
      req.data_value = '0;
      csr_we = 1'b0;
      csr_index = CSR_HASH_SELECT;
      csr_wdata = '0;
      hold_off = 1'b0;
      burst_left = 0;
      sent = 0;
      for (int k = 0; k < POOL; k++) begin
         pool_key[k] = {$urandom, $urandom};
         pool_len[k] = (k % 5 == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      end
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme keys and values, empty key, saturated length,
      // duplicates, tombstones, unused code, empty delete
      send_beat(CMD_DELETE, 64'h1234, 4'd2, 32'h0);
      send_beat(CMD_INSERT, 64'h61, 4'd1, 32'h0);
      send_beat(CMD_INSERT, ones, 4'd0, 32'hffffffff);
      send_beat(CMD_INSERT, ones, 4'd8, 32'h5a5a5a5a);
      send_beat(CMD_INSERT, ones, 4'd15, 32'ha5a5a5a5);
      send_beat(CMD_SEARCH, ones, 4'd8, 32'h0);
      send_beat(CMD_SEARCH, 64'hff61, 4'd1, 32'h0);
      send_beat(CMD_SEARCH, 64'h62, 4'd1, 32'h0);
      send_beat(CMD_DELETE, 64'h0, 4'd0, 32'h0);
      send_beat(CMD_DELETE, 64'h0, 4'd0, 32'h0);
      send_beat(CMD_SEARCH, ones, 4'd0, 32'h0);
      send_beat(CMD_INSERT, 64'h0, 4'd0, 32'h11111111);
      send_beat(CMD_NOP, ones, 4'd15, ones[31:0]);
      send_beat(CMD_SEARCH, 64'h0, 4'd0, 32'h0);
      send_beat(CMD_DELETE, ones, 4'd9, 32'h0);
      send_beat(CMD_DELETE, ones, 4'd8, 32'h0);
      drain();
      write_reg(CSR_TABLE_SIZE, 9'd1);
      send_beat(CMD_INSERT, 64'h7, 4'd3, 32'h0);
      send_beat(CMD_SEARCH, 64'h61, 4'd1, 32'h0);
      drain();
      write_reg(CSR_TABLE_SIZE, 9'd256);
      send_beat(CMD_DELETE, 64'h61, 4'd1, 32'h0);
      send_beat(CMD_DELETE, 64'h0, 4'd0, 32'h0);
      drain();
      empty_table();

      // random phases over the config space, table emptied between them
      for (int ph = 0; ph < 12; ph++) begin
         drain();
         write_reg(CSR_HASH_SELECT, CSR_DATA_W'(ph % 2));
         write_reg(CSR_PROBE_MODE, CSR_DATA_W'((ph / 2) % 2));
         write_reg(CSR_TABLE_SIZE, sizes[ph]);
         for (int n = 0; n < 50; n++) begin
            if (n == 20 && ph == 1) hold_off = 1'b1;  // block backs up, input stalls
            if (n == 30 && ph % 3 == 2) drain();      // sender waits for all beats
            roll = $urandom_range(0, 99);
            p = $urandom_range(0, POOL - 1);
            if (roll < 42) cmd = CMD_INSERT;
            else if (roll < 75) cmd = CMD_SEARCH;
            else if (roll < 95) cmd = CMD_DELETE;
            else cmd = CMD_NOP;
            if (cmd != CMD_INSERT && $urandom_range(0, 6) == 0)
               send_beat(cmd, {$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom);
            else
               send_beat(cmd, pool_bytes(p), pool_len[p], $urandom);
         end
         drain();
         empty_table();
      end
      drain();

      $display("covered %0d commands over 12 config phases (sizes 0 to 511, both hashes",
               sent);
      $display("and probe modes): ok %0d, not found %0d, full %0d, no free slot %0d",
               hit_count, miss_count, full_count, noslot_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("timeout with %0d responses outstanding", pending);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
